/* hw/rtl/ovl_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered value list package
// Field widths, request and reply codes, and the command and status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    start;         // capture the request and clear the scan pointer
    logic    append_wr;     // write the value at the tail and grow the list
    logic    search;        // walk the list looking for the value
    logic    shift;         // move later entries down by one
    logic    remove_commit; // shrink the list after the gap is closed
    logic    reply;         // load the result register
    status_t reply_status;
    logic    reply_use_pos; // report the match index rather than zero
  } ovl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  hit;
    logic  miss;
    logic  shift_done;
    logic  out_free;
  } ovl_stat_t;

endpackage

/* hw/rtl/ovl_req_if.sv */
// ----------------------------------------------------------------------------
// Ordered value list request channel
// Valid/ready channel carrying the request kind and the value.
// ----------------------------------------------------------------------------
interface ovl_req_if import ovl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

/* hw/rtl/ovl_rsp_if.sv */
// ----------------------------------------------------------------------------
// Ordered value list reply channel
// Valid/ready channel carrying the status, position and list length.
// ----------------------------------------------------------------------------
interface ovl_rsp_if import ovl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output status, output position, output length,
                  input ready);
  modport sink   (input valid, input status, input position, input length,
                  output ready);
endinterface

/* hw/rtl/ovl_ram.sv */
// ----------------------------------------------------------------------------
// Ordered value list RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ovl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ovl_datapath.sv */
// ----------------------------------------------------------------------------
// Ordered value list datapath
// Entry store, length counter, scan and shift pointers, and result register.
// ----------------------------------------------------------------------------
module ovl_datapath import ovl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KIND_W-1:0]   req_kind,
  input  logic [VALUE_W-1:0]  req_value,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] rsp_status,
  output logic [POS_W-1:0]    rsp_position,
  output logic [LEN_W-1:0]    rsp_length,
  input  ovl_cmd_t            cmd,
  output ovl_stat_t           stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  kind_t              kind;
  logic [VALUE_W-1:0] value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_idx;
  logic [AW-1:0]      match_idx;
  logic [CW-1:0]      rp;
  logic [AW-1:0]      wp;
  logic               pend;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               scan_issue;
  logic               shift_issue;
  logic               hit;
  logic [AW+POS_W-1:0] pos_wide;
  logic [CW+LEN_W-1:0] len_wide;

  assign scan_issue  = cmd.search && (scan < count);
  assign shift_issue = cmd.shift && (rp < count);
  assign hit         = cmp_vld && (ram_rdata == value);

  assign ram_we    = cmd.append_wr || (cmd.shift && pend);
  assign ram_waddr = cmd.shift ? wp : count[AW-1:0];
  assign ram_wdata = cmd.shift ? ram_rdata : value;
  assign ram_raddr = cmd.shift ? rp[AW-1:0] : scan[AW-1:0];

  ovl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request capture and the list length.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind  <= kind_t'(req_kind);
      value <= req_value;
    end
    if (rst) begin
      count <= '0;
    end else if (cmd.append_wr) begin
      count <= count + CW'(1);
    end else if (cmd.remove_commit) begin
      count <= count - CW'(1);
    end
  end

  // Scan pointer; the compare runs in the cycle after the RAM read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      scan    <= '0;
    end else begin
      cmp_vld <= scan_issue;
      if (cmd.start) begin
        scan <= '0;
      end else if (scan_issue) begin
        scan <= scan + CW'(1);
      end
    end
    cmp_idx <= scan[AW-1:0];
  end

  // Match capture and gap closing: read at rp, write the previous read at wp.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.search && hit) begin
      pend <= 1'b0;
    end else if (cmd.shift) begin
      pend <= shift_issue;
    end
    if (cmd.search && hit) begin
      match_idx <= cmp_idx;
      rp        <= CW'(cmp_idx) + CW'(1);
      wp        <= cmp_idx;
    end else if (cmd.shift) begin
      if (shift_issue) begin
        rp <= rp + CW'(1);
      end
      if (pend) begin
        wp <= wp + AW'(1);
      end
    end
  end

  // Result register: fields wider than the reply are reported modulo its width.
  assign pos_wide = {{POS_W{1'b0}}, match_idx};
  assign len_wide = {{LEN_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.reply && stat.out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.reply && stat.out_free) begin
      rsp_status   <= cmd.reply_status;
      rsp_position <= cmd.reply_use_pos ? pos_wide[POS_W-1:0] : '0;
      rsp_length   <= len_wide[LEN_W-1:0];
    end
  end

  always_comb begin
    stat.kind       = kind;
    stat.full       = (count == CW'(CAPACITY));
    stat.hit        = hit;
    stat.miss       = !cmp_vld && (scan >= count);
    stat.shift_done = !pend && (rp >= count);
    stat.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

/* hw/rtl/ovl_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered value list controller
// State machine sequencing decode, search, gap closing and reply.
// ----------------------------------------------------------------------------
module ovl_ctrl import ovl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ovl_stat_t stat,
  output ovl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t  state, state_next;
  status_t rep_status, rep_status_next;
  logic    rep_use_pos, rep_use_pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rep_status  <= ST_NOT_FOUND;
      rep_use_pos <= 1'b0;
    end else begin
      state       <= state_next;
      rep_status  <= rep_status_next;
      rep_use_pos <= rep_use_pos_next;
    end
  end

  always_comb begin
    state_next        = state;
    rep_status_next   = rep_status;
    rep_use_pos_next  = rep_use_pos;
    req_ready         = 1'b0;
    cmd               = '0;
    cmd.reply_status  = rep_status;
    cmd.reply_use_pos = rep_use_pos;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.start = req_valid;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        rep_use_pos_next = 1'b0;
        case (stat.kind)
          KIND_APPEND: begin
            if (stat.full) begin
              rep_status_next = ST_FULL;
            end else begin
              cmd.append_wr   = 1'b1;
              rep_status_next = ST_OK;
            end
            state_next = S_REPLY;
          end
          KIND_REMOVE, KIND_FIND: begin
            state_next = S_SEARCH;
          end
          default: begin
            rep_status_next = ST_NOT_FOUND;
            state_next      = S_REPLY;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.hit) begin
          rep_status_next  = ST_OK;
          rep_use_pos_next = 1'b1;
          state_next       = (stat.kind == KIND_REMOVE) ? S_SHIFT : S_REPLY;
        end else if (stat.miss) begin
          rep_status_next  = ST_NOT_FOUND;
          rep_use_pos_next = 1'b0;
          state_next       = S_REPLY;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          cmd.remove_commit = 1'b1;
          state_next        = S_REPLY;
        end
      end
      S_REPLY: begin
        cmd.reply = 1'b1;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ordered_value_list_top.sv */
// ----------------------------------------------------------------------------
// Ordered value list
// Bounded, ordered list of signed 32-bit values with append, remove and find.
// ----------------------------------------------------------------------------
// Each request transfer on req gives exactly one reply transfer on rsp, in
// order. Append stores the value after the last entry, or replies full once
// CAPACITY entries are held. Remove deletes the first entry equal to the
// value and moves every later entry down by one, so order is kept. Find
// reports the index of the first equal entry. Every reply also carries the
// number of entries held after the request; position and length are reported
// modulo 16 and 32 when CAPACITY is larger than their fields. One request is
// handled at a time and the entries sit in a single RAM with one read and one
// write port: the search reads one entry a cycle, and a remove closes the gap
// by copying one entry a cycle through the same port pair; when the match is
// the last entry, nothing has to move. The reply sits in an output register,
// so a new request is taken as soon as the previous reply is loaded, even
// while it still waits to be taken. The entry RAM needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module ordered_value_list_top import ovl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  ovl_req_if.sink    req,
  ovl_rsp_if.source  rsp
);

  ovl_cmd_t  cmd;
  ovl_stat_t stat;

  // The controller owns the request handshake; the datapath owns the reply
  // register and therefore the reply handshake.
  ovl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ovl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_kind     (req.kind),
    .req_value    (req.value),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position),
    .rsp_length   (rsp.length),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
